### hw/rtl/stack_register_vm_core_defines.svh
// Assertion macros shared by the stack machine core RTL.
`ifndef STACK_REGISTER_VM_CORE_DEFINES_SVH
`define STACK_REGISTER_VM_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and switched off while rst_n is low.
`define SRVM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and switched off while rst_n is low.
`define SRVM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/srvm_pkg.sv
// Constants, codes and helper functions of the stack machine core.
`default_nettype none

package srvm_pkg;

    localparam int REG_COUNT   = 4;
    localparam int STACK_DEPTH = 256;
    localparam int VAR_COUNT   = 16;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 4;
    localparam int REG_FW = 2;
    localparam int VAR_FW = 4;
    localparam int STAT_W = 2;

    localparam int REG_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int VAR_AW     = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int DATA_DEPTH = REG_COUNT + VAR_COUNT;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);
    localparam int STACK_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CW     = $clog2(DATA_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 4'd0,
        CMD_PUSH_REG = 4'd1,
        CMD_POP      = 4'd2,
        CMD_READ     = 4'd3,
        CMD_LOAD     = 4'd4,
        CMD_ADD      = 4'd5,
        CMD_SUB      = 4'd6,
        CMD_MUL      = 4'd7,
        CMD_DIV      = 4'd8,
        CMD_ASSIGN   = 4'd9,
        CMD_RETURN   = 4'd10,
        CMD_END      = 4'd11
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    function automatic logic [REG_AW-1:0] reg_sel(input logic [REG_FW-1:0] r);
        if (32'(r) >= REG_COUNT)
        begin
            return REG_AW'(REG_COUNT - 1);
        end
        return REG_AW'(r);
    endfunction

    function automatic logic [VAR_AW-1:0] var_sel(input logic [VAR_FW-1:0] v);
        if (32'(v) >= VAR_COUNT)
        begin
            return VAR_AW'(VAR_COUNT - 1);
        end
        return VAR_AW'(v);
    endfunction

    function automatic logic [DATA_AW-1:0] reg_addr(input logic [REG_AW-1:0] r);
        return DATA_AW'(r);
    endfunction

    function automatic logic [DATA_AW-1:0] var_addr(input logic [VAR_AW-1:0] v);
        return DATA_AW'(REG_COUNT) + DATA_AW'(v);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/srvm_cmd_if.sv
// Instruction channel of the stack machine core.
`default_nettype none

interface srvm_cmd_if import srvm_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] immediate;
    logic [REG_FW-1:0]        first_reg;
    logic [REG_FW-1:0]        second_reg;
    logic [VAR_FW-1:0]        var_index;

    modport source (
        output valid, command, immediate, first_reg, second_reg, var_index,
        input  ready
    );

    modport sink (
        input  valid, command, immediate, first_reg, second_reg, var_index,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/srvm_res_if.sv
// Result channel of the stack machine core.
`default_nettype none

interface srvm_res_if import srvm_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     finished;
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;

    modport source (
        output valid, finished, result_value, status,
        input  ready
    );

    modport sink (
        input  valid, finished, result_value, status,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/srvm_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none

module srvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                          rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                          rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### hw/rtl/srvm_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module srvm_divider import srvm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] quotient_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W-1:0] rem_step;
    logic [DATA_W-1:0] quo_step;
    logic              last_step;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        fits      = !trial[DATA_W];
        rem_step  = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_step  = {quo_reg[DATA_W-2:0], fits};
        last_step = (cnt_reg == DIV_CW'(DATA_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dsr_reg <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (last_step)
            begin
                quotient_reg <= neg_reg ? (DATA_W'(0) - quo_step) : quo_step;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

`default_nettype wire

### hw/rtl/stack_register_vm_core.sv
// Top level of the register-plus-stack machine core: sequencer and state memories.
//
//   Channel  Role    Carries
//   instr    sink    command, immediate, first_reg, second_reg, var_index
//   result   source  finished, result_value, status
//
// An instruction passes through acceptance, memory read and execution, completion (S_IDLE, S_EXEC, S_DONE).
// A divide also waits in S_DIV on the one-bit-per-cycle divider.
// After reset the block is ready at once; registers and variables read as zero until written.
// A new request is taken while a finished result still waits in the output register.
`default_nettype none
`include "stack_register_vm_core_defines.svh"

module stack_register_vm_core import srvm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    srvm_cmd_if.sink     instr,
    srvm_res_if.source   result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [VAR_AW-1:0]    sel_var_reg, sel_var_next;
    logic [DATA_DEPTH-1:0] data_valid_reg;
    logic                 out_valid_reg;

    logic [CMD_W-1:0]     cmd_reg;
    logic [DATA_W-1:0]    imm_reg;
    logic [VAR_AW-1:0]    var_reg;
    logic [DATA_AW-1:0]   dst_addr_reg;
    logic [DATA_AW-1:0]   rd_a_addr_reg;
    logic [DATA_AW-1:0]   rd_b_addr_reg;
    logic                 fin_reg, fin_next;
    logic [DATA_W-1:0]    res_reg, res_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic                 out_fin_reg;
    logic [DATA_W-1:0]    out_res_reg;
    logic [STAT_W-1:0]    out_status_reg;

    logic                 accept;
    logic                 out_load;
    logic [DATA_AW-1:0]   rd_a_addr;
    logic [DATA_AW-1:0]   rd_b_addr;
    logic [DATA_W-1:0]    data_rdata_a;
    logic [DATA_W-1:0]    data_rdata_b;
    logic                 data_we;
    logic [DATA_AW-1:0]   data_waddr;
    logic [DATA_W-1:0]    data_wdata;
    logic [SP_W-1:0]      sp_dec;
    logic                 stk_we;
    logic [DATA_W-1:0]    stk_rdata;
    logic [DATA_W-1:0]    op_a;
    logic [DATA_W-1:0]    op_b;
    logic [DATA_W-1:0]    product;
    logic                 push_req;
    logic [DATA_W-1:0]    push_val;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_quotient;

    assign accept       = instr.valid && instr.ready;
    assign instr.ready  = (state_reg == S_IDLE);
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign sp_dec       = sp_reg - SP_W'(1);

    assign rd_a_addr = (instr.command == CMD_LOAD) ? var_addr(sel_var_reg)
                                                   : reg_addr(reg_sel(instr.first_reg));
    assign rd_b_addr = (instr.command == CMD_ASSIGN) ? reg_addr(REG_AW'(0))
                                                     : reg_addr(reg_sel(instr.second_reg));

    srvm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .we      (data_we),
        .waddr   (data_waddr),
        .wdata   (data_wdata),
        .raddr_a (rd_a_addr),
        .rdata_a (data_rdata_a),
        .raddr_b (rd_b_addr),
        .rdata_b (data_rdata_b)
    );

    srvm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .we      (stk_we),
        .waddr   (sp_reg[STACK_AW-1:0]),
        .wdata   (push_val),
        .raddr_a (sp_dec[STACK_AW-1:0]),
        .rdata_a (stk_rdata),
        .raddr_b (sp_reg[STACK_AW-1:0]),
        .rdata_b ()
    );

    srvm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (op_a),
        .divisor  (op_b),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        op_a    = data_valid_reg[rd_a_addr_reg] ? data_rdata_a : '0;
        op_b    = data_valid_reg[rd_b_addr_reg] ? data_rdata_b : '0;
        product = op_a * op_b;
    end

    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        sel_var_next = sel_var_reg;
        fin_next     = fin_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        data_we      = 1'b0;
        data_waddr   = dst_addr_reg;
        data_wdata   = '0;
        stk_we       = 1'b0;
        push_req     = 1'b0;
        push_val     = '0;
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (instr.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                fin_next    = 1'b0;
                res_next    = '0;
                status_next = ST_OK;
                state_next  = S_DONE;
                unique case (cmd_reg)
                    CMD_PUSH:
                    begin
                        push_req = 1'b1;
                        push_val = imm_reg;
                    end
                    CMD_PUSH_REG:
                    begin
                        push_req = 1'b1;
                        push_val = op_a;
                    end
                    CMD_POP:
                    begin
                        if (sp_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            sp_next    = sp_dec;
                            data_we    = 1'b1;
                            data_wdata = stk_rdata;
                        end
                    end
                    CMD_READ:
                    begin
                        sel_var_next = var_reg;
                    end
                    CMD_LOAD:
                    begin
                        data_we    = 1'b1;
                        data_wdata = op_a;
                    end
                    CMD_ADD:
                    begin
                        push_req = 1'b1;
                        push_val = op_a + op_b;
                    end
                    CMD_SUB:
                    begin
                        push_req = 1'b1;
                        push_val = op_a - op_b;
                    end
                    CMD_MUL:
                    begin
                        push_req = 1'b1;
                        push_val = product;
                    end
                    CMD_DIV:
                    begin
                        if (op_b == '0)
                        begin
                            status_next = ST_DIVZ;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    CMD_ASSIGN:
                    begin
                        data_we    = 1'b1;
                        data_waddr = var_addr(sel_var_reg);
                        data_wdata = op_b;
                    end
                    CMD_RETURN:
                    begin
                        fin_next = 1'b1;
                        res_next = op_a;
                    end
                    CMD_END:
                    begin
                        fin_next = 1'b1;
                        if (sp_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            sp_next  = sp_dec;
                            res_next = stk_rdata;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    push_req   = 1'b1;
                    push_val   = div_quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_req)
        begin
            if (sp_reg >= SP_W'(STACK_DEPTH))
            begin
                status_next = ST_OVER;
            end
            else
            begin
                stk_we  = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            sel_var_reg    <= '0;
            data_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            sel_var_reg <= sel_var_next;
            if (data_we)
            begin
                data_valid_reg[data_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= instr.command;
            imm_reg       <= instr.immediate;
            var_reg       <= var_sel(instr.var_index);
            dst_addr_reg  <= reg_addr(reg_sel(instr.first_reg));
            rd_a_addr_reg <= rd_a_addr;
            rd_b_addr_reg <= rd_b_addr;
        end
        fin_reg    <= fin_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_fin_reg    <= fin_reg;
            out_res_reg    <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.finished     = out_fin_reg;
    assign result.result_value = out_res_reg;
    assign result.status       = out_status_reg;

    `SRVM_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= SP_W'(STACK_DEPTH), "Stack pointer beyond depth.")
    `SRVM_ASSERT_IMP(a_push_room, stk_we, sp_reg < SP_W'(STACK_DEPTH), "Push into a full stack.")
    `SRVM_ASSERT_IMP(a_div_state, div_done, state_reg == S_DIV, "Quotient with no divide waiting.")
    `SRVM_ASSERT_IMP(a_one_write, data_we, !stk_we, "Two memory writes for one request.")
    `SRVM_ASSERT_NXT(a_out_fill, (state_reg == S_DONE) && !out_valid_reg, out_valid_reg, "Result lost.")

endmodule

`default_nettype wire
